/* rtl/kti_pkg.sv */
`timescale 1ns / 1ps
package kti_pkg;

   localparam int NUM_WORDS = 9;
   localparam int CFG_WIDTH = 5;
   localparam logic [CFG_WIDTH-1:0] KEY_COUNT_RESET = 5'd1;

   localparam logic [1:0] FUNC_KEY    = 2'd0;
   localparam logic [1:0] FUNC_BASE   = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [3:0] SEL_TIME  = 4'd0;
   localparam logic [3:0] SEL_FIRST = 4'd1;
   localparam logic [3:0] SEL_LAST  = 4'd9;
   localparam logic [3:0] SEL_FLAGS = 4'd10;

   localparam logic [1:0] CH_POS = 2'd0;
   localparam logic [1:0] CH_ROT = 2'd1;
   localparam logic [1:0] CH_SCL = 2'd2;

   typedef logic [3:0] word_idx_type;
   localparam word_idx_type WORD_END = 4'd9;

   typedef struct packed {
      logic [1:0]         func;
      logic [3:0]         key_index;
      logic [3:0]         word_select;
      logic signed [31:0] word_value;
      logic [31:0]        delta_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      logic signed [31:0] scl_x;
      logic signed [31:0] scl_y;
      logic signed [31:0] scl_z;
      logic               pos_updated;
      logic               rot_updated;
      logic               scl_updated;
   } rsp_type;

   typedef struct packed {
      logic         accept;
      logic         check;
      logic         div_step;
      word_idx_type word;
      logic         rd_b;
      logic         mul_lerp;
      logic         lerp;
      logic         apply;
      logic         mul_scale;
      logic         store_scale;
      logic         load_rsp;
   } cmd_type;

   typedef struct packed {
      logic       advance;
      logic       recompute;
      logic [2:0] present;
   } status_type;

   function automatic logic [1:0] word_channel(word_idx_type w);
      logic [1:0] ch;
      if (w < 4'd3) begin
         ch = CH_POS;
      end else if (w < 4'd6) begin
         ch = CH_ROT;
      end else begin
         ch = CH_SCL;
      end
      return ch;
   endfunction

endpackage

/* rtl/kti_ram.sv */
`timescale 1ns / 1ps
module kti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

/* rtl/kti_datapath.sv */
`timescale 1ns / 1ps
module kti_datapath #(
   parameter int MAX_KEYS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kti_pkg::req_type                 req_data,
   input  logic                             csr_write,
   input  logic [kti_pkg::CFG_WIDTH-1:0]    csr_data,
   input  kti_pkg::cmd_type                 cmd,
   output kti_pkg::status_type              status,
   output kti_pkg::rsp_type                 rsp_data
);

   localparam int KW = $clog2(MAX_KEYS);
   localparam int CW = ($clog2(MAX_KEYS + 1) > kti_pkg::CFG_WIDTH) ?
                       $clog2(MAX_KEYS + 1) : kti_pkg::CFG_WIDTH;
   localparam int VDEPTH = MAX_KEYS * kti_pkg::NUM_WORDS;
   localparam int VW = $clog2(VDEPTH);
   localparam int TW = FRAC_BITS + 1;
   localparam int PW = 66;
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   // control state
   logic [kti_pkg::CFG_WIDTH-1:0] key_count_ff;
   logic [31:0]                   elapsed_ff;
   logic [KW-1:0]                 key_ff;
   logic [KW-1:0]                 k1_ff;
   logic [2:0]                    upd_ff;
   logic signed [31:0]            base_ff [kti_pkg::NUM_WORDS];
   logic signed [31:0]            held_ff [kti_pkg::NUM_WORDS];

   // payload
   logic [32:0]           rem_ff;
   logic [31:0]           kt_ff;
   logic [TW-1:0]         t_ff;
   logic [2:0]            pres_ff;
   logic signed [31:0]    a_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [31:0]    lerp_ff;
   kti_pkg::rsp_type      rsp_ff;

   logic [CW-1:0]   cnt;
   logic [CW-1:0]   nxt;
   logic [KW-1:0]   k1;
   logic [32:0]     sum33;
   logic [31:0]     elapsed_in;
   logic            key_we;
   logic            time_we;
   logic            val_we;
   logic            pres_we;
   logic [VW-1:0]   val_waddr;
   logic [VW-1:0]   val_raddr;
   logic [31:0]     time_rdata;
   logic [31:0]     val_rdata;
   logic [2:0]      pres_rdata;
   logic            div_bit;
   logic [32:0]     div_diff;
   logic signed [32:0]    mul_a;
   logic signed [32:0]    mul_b;
   logic signed [PW-1:0]  a_wide;
   logic signed [PW-1:0]  lerp_sum;
   logic signed [PW-1:0]  scale_sum;
   logic signed [PW-1:0]  scale_shr;
   logic signed [32:0]    add_sum;
   logic signed [31:0]    add_sat;
   logic signed [31:0]    scale_sat;
   logic [1:0]            ch;

   // next key in the loop
   always_comb begin
      cnt = CW'(key_count_ff);
      if (cnt == '0) begin
         cnt = CW'(1);
      end
      if (cnt > CW'(MAX_KEYS)) begin
         cnt = CW'(MAX_KEYS);
      end
      nxt = CW'(key_ff) + CW'(1);
      k1 = (nxt >= cnt) ? '0 : nxt[KW-1:0];
   end

   assign sum33 = {1'b0, elapsed_ff} + {1'b0, req_data.delta_time};
   assign elapsed_in = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];

   assign key_we = cmd.accept && (req_data.func == kti_pkg::FUNC_KEY) &&
                   (32'(req_data.key_index) < MAX_KEYS);
   assign time_we = key_we && (req_data.word_select == kti_pkg::SEL_TIME);
   assign pres_we = key_we && (req_data.word_select == kti_pkg::SEL_FLAGS);
   assign val_we  = key_we && (req_data.word_select >= kti_pkg::SEL_FIRST) &&
                    (req_data.word_select <= kti_pkg::SEL_LAST);

   assign val_waddr = VW'(req_data.key_index) * VW'(kti_pkg::NUM_WORDS) +
                      VW'(req_data.word_select - kti_pkg::SEL_FIRST);
   assign val_raddr = (cmd.rd_b ? VW'(k1_ff) : VW'(key_ff)) * VW'(kti_pkg::NUM_WORDS) +
                      VW'(cmd.word);

   kti_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
      .clock      (clock),
      .write_en   (time_we),
      .write_addr (KW'(req_data.key_index)),
      .write_data (req_data.word_value),
      .read_addr  (k1),
      .read_data  (time_rdata)
   );

   kti_ram #(.WIDTH(3), .DEPTH(MAX_KEYS)) u_pres_ram (
      .clock      (clock),
      .write_en   (pres_we),
      .write_addr (KW'(req_data.key_index)),
      .write_data (req_data.word_value[2:0]),
      .read_addr  (key_ff),
      .read_data  (pres_rdata)
   );

   kti_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_value_ram (
      .clock      (clock),
      .write_en   (val_we),
      .write_addr (val_waddr),
      .write_data (req_data.word_value),
      .read_addr  (val_raddr),
      .read_data  (val_rdata)
   );

   assign status.advance   = elapsed_ff > time_rdata;
   assign status.recompute = !(elapsed_ff > time_rdata) && (elapsed_ff != '0);
   assign status.present   = pres_ff;

   // one quotient bit per step, remainder stays below key time
   assign div_bit  = rem_ff >= {1'b0, kt_ff};
   assign div_diff = div_bit ? (rem_ff - {1'b0, kt_ff}) : rem_ff;

   assign ch = kti_pkg::word_channel(cmd.word);

   // shared multiplier operands
   always_comb begin
      if (cmd.mul_scale) begin
         mul_a = {base_ff[cmd.word][31], base_ff[cmd.word]};
         mul_b = {lerp_ff[31], lerp_ff};
      end else begin
         mul_a = $signed({val_rdata[31], val_rdata}) - $signed({a_ff[31], a_ff});
         mul_b = $signed(33'(t_ff));
      end
   end

   assign a_wide   = $signed({{(PW-32){a_ff[31]}}, a_ff}) <<< FRAC_BITS;
   assign lerp_sum = prod_ff + a_wide + $signed(HALF);

   assign scale_sum = prod_ff + $signed(HALF);
   assign scale_shr = scale_sum >>> FRAC_BITS;
   always_comb begin
      if ((&scale_shr[PW-1:31]) || !(|scale_shr[PW-1:31])) begin
         scale_sat = scale_shr[31:0];
      end else begin
         scale_sat = scale_shr[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   end

   assign add_sum = $signed({base_ff[cmd.word][31], base_ff[cmd.word]}) +
                    $signed({lerp_ff[31], lerp_ff});
   always_comb begin
      if (add_sum[32] == add_sum[31]) begin
         add_sat = add_sum[31:0];
      end else begin
         add_sat = add_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= kti_pkg::KEY_COUNT_RESET;
         elapsed_ff <= '0;
         key_ff <= '0;
         k1_ff <= '0;
         upd_ff <= '0;
         for (int i = 0; i < kti_pkg::NUM_WORDS; i++) begin
            base_ff[i] <= '0;
            held_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            key_count_ff <= csr_data;
         end
         if (cmd.accept && (req_data.func == kti_pkg::FUNC_BASE) &&
             (req_data.word_select >= kti_pkg::SEL_FIRST) &&
             (req_data.word_select <= kti_pkg::SEL_LAST)) begin
            base_ff[req_data.word_select - kti_pkg::SEL_FIRST] <= req_data.word_value;
         end
         if (cmd.accept && (req_data.func == kti_pkg::FUNC_TICK)) begin
            elapsed_ff <= elapsed_in;
            k1_ff <= k1;
            upd_ff <= '0;
         end
         if (cmd.check && status.advance) begin
            key_ff <= k1_ff;
            elapsed_ff <= '0;
         end
         if (cmd.apply) begin
            held_ff[cmd.word] <= add_sat;
            upd_ff[ch] <= 1'b1;
         end
         if (cmd.store_scale) begin
            held_ff[cmd.word] <= scale_sat;
            upd_ff[ch] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         rem_ff <= {1'b0, elapsed_ff};
         kt_ff <= time_rdata;
         pres_ff <= pres_rdata;
         t_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= {div_diff[31:0], 1'b0};
         t_ff <= {t_ff[TW-2:0], div_bit};
      end
      if (cmd.rd_b) begin
         a_ff <= val_rdata;
      end
      if (cmd.mul_lerp || cmd.mul_scale) begin
         prod_ff <= PW'(mul_a * mul_b);
      end
      if (cmd.lerp) begin
         lerp_ff <= lerp_sum[FRAC_BITS+31:FRAC_BITS];
      end
      if (cmd.load_rsp) begin
         rsp_ff.pos_x <= held_ff[0];
         rsp_ff.pos_y <= held_ff[1];
         rsp_ff.pos_z <= held_ff[2];
         rsp_ff.rot_x <= held_ff[3];
         rsp_ff.rot_y <= held_ff[4];
         rsp_ff.rot_z <= held_ff[5];
         rsp_ff.scl_x <= held_ff[6];
         rsp_ff.scl_y <= held_ff[7];
         rsp_ff.scl_z <= held_ff[8];
         rsp_ff.pos_updated <= upd_ff[0];
         rsp_ff.rot_updated <= upd_ff[1];
         rsp_ff.scl_updated <= upd_ff[2];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/kti_controller.sv */
`timescale 1ns / 1ps
module kti_controller #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kti_pkg::cmd_type    cmd,
   input  kti_pkg::status_type status
);

   localparam int DCW = $clog2(FRAC_BITS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_NEXT,
      ST_RD_A,
      ST_RD_B,
      ST_MUL,
      ST_LERP,
      ST_APPLY,
      ST_SCALE,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic                  rsp_valid_ff;
   kti_pkg::word_idx_type word_ff;
   logic [DCW-1:0]        div_cnt_ff;
   logic [1:0]            ch;
   logic                  slot_free;

   assign ch = kti_pkg::word_channel(word_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         word_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_func == kti_pkg::FUNC_TICK)) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               div_cnt_ff <= '0;
               word_ff <= '0;
               state_ff <= status.recompute ? ST_DIV : ST_FINISH;
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff + DCW'(1);
               if (div_cnt_ff == DCW'(FRAC_BITS)) begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (word_ff == kti_pkg::WORD_END) begin
                  state_ff <= ST_FINISH;
               end else if (status.present[ch]) begin
                  state_ff <= ST_RD_A;
               end else begin
                  word_ff <= word_ff + 4'd1;
               end
            end
            ST_RD_A: state_ff <= ST_RD_B;
            ST_RD_B: state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_LERP;
            ST_LERP: state_ff <= ST_APPLY;
            ST_APPLY: begin
               if (ch == kti_pkg::CH_SCL) begin
                  state_ff <= ST_SCALE;
               end else begin
                  word_ff <= word_ff + 4'd1;
                  state_ff <= ST_NEXT;
               end
            end
            ST_SCALE: begin
               word_ff <= word_ff + 4'd1;
               state_ff <= ST_NEXT;
            end
            ST_FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.word = word_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.accept = req_valid;
         ST_CHECK:  cmd.check = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_RD_B:   cmd.rd_b = 1'b1;
         ST_MUL:    cmd.mul_lerp = 1'b1;
         ST_LERP:   cmd.lerp = 1'b1;
         ST_APPLY: begin
            if (ch == kti_pkg::CH_SCL) begin
               cmd.mul_scale = 1'b1;
            end else begin
               cmd.apply = 1'b1;
            end
         end
         ST_SCALE:  cmd.store_scale = 1'b1;
         ST_FINISH: cmd.load_rsp = slot_free;
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_func == kti_pkg::FUNC_TICK)
      |=> (state_ff == ST_CHECK))
      else $error("tick request did not start the sequence");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff <= DCW'(FRAC_BITS)))
      else $error("divide step count overran");

   a_word_bound: assert property (@(posedge clock) disable iff (reset)
      (word_ff <= kti_pkg::WORD_END))
      else $error("word index out of range");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && slot_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not posted at finish");

endmodule

/* rtl/keyframe_transform_interpolator.sv */
`timescale 1ns / 1ps
// write requests are accepted while idle; a tick that steps the key or has zero time goes
// through check and finish; a tick that interpolates runs check, a bit-serial divide, then
// next, read A, read B, multiply, lerp and apply per translation/rotation word, plus a scale
// step per scale word and only the next state per skipped word; one shared multiplier
// a finished tick waits in its finish state while the previous response is still stalled
// sync active-high reset clears base/held words, time, key index, key count to 1, not key tables
module keyframe_transform_interpolator #(
   parameter int MAX_KEYS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  kti_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output kti_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kti_pkg::CFG_WIDTH-1:0] csr_data
);

   kti_pkg::cmd_type    cmd;
   kti_pkg::status_type status;

   assign csr_ready = 1'b1;

   kti_controller #(.FRAC_BITS(FRAC_BITS)) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   kti_datapath #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
